@@ rtl/core/evq_pkg.sv @@
package evq_pkg;

  // default ring size; the ring holds one event fewer than this
  localparam int EVQ_DEPTH_DEF = 128;

  // request selector codes
  localparam logic [1:0] FUNC_KEY   = 2'd0;
  localparam logic [1:0] FUNC_MOUSE = 2'd1;
  localparam logic [1:0] FUNC_POP   = 2'd2;

  // evdev numbering
  localparam logic [15:0] EV_KEY      = 16'h0001;
  localparam logic [15:0] EV_REL      = 16'h0002;
  localparam logic [15:0] REL_X       = 16'h0000;
  localparam logic [15:0] REL_Y       = 16'h0001;
  localparam logic [15:0] REL_SCROLL  = 16'h0008;
  localparam logic [15:0] KEY_MOUSE_L = 16'h0110;
  localparam logic [15:0] KEY_MOUSE_R = 16'h0111;
  localparam logic [15:0] KEY_MOUSE_M = 16'h0112;

  // mouse report step bits, written in this order
  localparam int STEP_X   = 0;
  localparam int STEP_Y   = 1;
  localparam int STEP_W   = 2;
  localparam int STEP_L   = 3;
  localparam int STEP_R   = 4;
  localparam int STEP_M   = 5;
  localparam int N_STEPS  = 6;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         scancode;
    logic               key_pressed;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] wheel_delta;
    logic               button_left;
    logic               button_right;
    logic               button_middle;
  } evq_in_t;

  typedef struct packed {
    logic               event_found;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } evq_out_t;

  typedef struct packed {
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } evq_entry_t;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_MOUSE = 2'd1,
    OP_POP   = 2'd2
  } evq_op_t;

  // classified request handed from front to back
  typedef struct packed {
    evq_op_t              op;
    logic [N_STEPS-1:0]   steps;
    evq_in_t              req;
  } evq_cmd_t;

endpackage

@@ rtl/core/input_event_ring_queue_core.sv @@
// Channel   Ports                          Direction  Moves
// -------   -----------------------------  ---------  ---------------------------------
// input     in_push, in_full, in_data      in         one request (key, mouse, pop)
// result    out_empty, out_pop, out_data   out        one pop result (event or not found)
//
// Front takes one request per cycle while its two-slot request queue has room;
// a selector of 3 is taken there and discarded.
// Back runs requests in order: key push (one ring write as taken), mouse report (take,
// then one ring write per event through the single write port), pop (read, then result).
// Reset (rst_n low, synchronous) empties both queues and the ring indices, not the ring.
// A pop waits in back until the two-slot result queue has room, holding later requests.
module input_event_ring_queue_core import evq_pkg::*; #(
  parameter int QUEUE_DEPTH = EVQ_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  evq_in_t  in_data,
  output logic     out_empty,
  input  logic     out_pop,
  output evq_out_t out_data
);

  // front to back: classified requests
  logic     cmd_avail;
  logic     cmd_take;
  evq_cmd_t cmd;

  // back to result queue
  logic     res_full;
  logic     res_push;
  evq_out_t res_data;

  evq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_avail (cmd_avail),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // ring store, indices and the per-request sequencer
  evq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (cmd_avail),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // results wait here so the back end keeps going while the consumer stalls
  evq_rsq u_rsq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/evq_front.sv @@
module evq_front import evq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  evq_in_t  in_data,
  output logic     cmd_avail,
  output evq_cmd_t cmd,
  input  logic     cmd_take
);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  evq_cmd_t         cq_r [CQ_DEPTH];
  logic [CQ_PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             acc, enq;
  evq_cmd_t         cls;

  assign in_full   = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign cmd_avail = (cnt_r != '0);
  assign cmd       = cq_r[rp_r];
  assign acc       = in_push && !in_full;

  // classify; unused selector is taken and dropped
  always_comb begin
    cls       = '0;
    cls.req   = in_data;
    enq       = 1'b0;
    unique case (in_data.func)
      FUNC_KEY: begin
        cls.op = OP_KEY;
        enq    = acc;
      end
      FUNC_MOUSE: begin
        cls.op              = OP_MOUSE;
        cls.steps[STEP_X]   = (in_data.delta_x != '0);
        cls.steps[STEP_Y]   = (in_data.delta_y != '0);
        cls.steps[STEP_W]   = (in_data.wheel_delta != '0);
        cls.steps[STEP_L]   = 1'b1;
        cls.steps[STEP_R]   = 1'b1;
        cls.steps[STEP_M]   = 1'b1;
        enq                 = acc;
      end
      FUNC_POP: begin
        cls.op = OP_POP;
        enq    = acc;
      end
      default: begin
        cls.op = OP_KEY;
        enq    = 1'b0;
      end
    endcase
  end

  always_comb begin
    wp_nxt  = enq ? CQ_PW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = cmd_take ? CQ_PW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = CQ_CW'(cnt_r + CQ_CW'(enq) - CQ_CW'(cmd_take));
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      cq_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/evq_rsq.sv @@
module evq_rsq import evq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_push,
  input  evq_out_t res_data,
  output logic     res_full,
  output logic     out_empty,
  input  logic     out_pop,
  output evq_out_t out_data
);

  localparam int RQ_DEPTH = 2;
  localparam int RQ_PW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  evq_out_t         q_r [RQ_DEPTH];
  logic [RQ_PW-1:0] wp_r, rp_r;
  logic [RQ_CW-1:0] cnt_r;
  logic             deq;

  assign res_full  = (cnt_r == RQ_CW'(RQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_data  = q_r[rp_r];
  assign deq       = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wp_r] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (res_push) begin
        wp_r <= RQ_PW'(wp_r + 1'b1);
      end
      if (deq) begin
        rp_r <= RQ_PW'(rp_r + 1'b1);
      end
      cnt_r <= RQ_CW'(cnt_r + RQ_CW'(res_push) - RQ_CW'(deq));
    end
  end

endmodule

@@ rtl/core/evq_back.sv @@
module evq_back import evq_pkg::*; #(
  parameter int QUEUE_DEPTH = EVQ_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_avail,
  input  evq_cmd_t cmd,
  output logic     cmd_take,
  input  logic     res_full,
  output logic     res_push,
  output evq_out_t res_data
);

  localparam int              IW   = $clog2(QUEUE_DEPTH);
  localparam logic [IW-1:0]   LAST = IW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MOUSE = 3'b010,
    S_POPRD = 3'b100
  } evq_bst_t;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : IW'(i + 1'b1);
  endfunction

  evq_entry_t         mem_r [QUEUE_DEPTH];
  evq_entry_t         rd_q_r;
  evq_bst_t           state_r, state_nxt;
  logic [IW-1:0]      wr_idx_r, wr_idx_nxt, rd_idx_r, rd_idx_nxt;
  logic [N_STEPS-1:0] steps_r, steps_nxt;
  evq_in_t            mreq_r;
  logic               found_r, found_nxt;
  logic               wr_en, rd_en, not_empty;
  evq_entry_t         wr_ent;

  assign not_empty = (rd_idx_r != wr_idx_r);

  always_comb begin
    state_nxt = state_r;
    steps_nxt = steps_r;
    found_nxt = found_r;
    cmd_take  = 1'b0;
    wr_en     = 1'b0;
    wr_ent    = '0;
    rd_en     = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_avail) begin
          unique case (cmd.op)
            OP_KEY: begin
              cmd_take = 1'b1;
              wr_en    = 1'b1;
              wr_ent   = '{EV_KEY, {8'd0, cmd.req.scancode},
                           {31'd0, cmd.req.key_pressed}};
            end
            OP_MOUSE: begin
              cmd_take  = 1'b1;
              steps_nxt = cmd.steps;
              state_nxt = S_MOUSE;
            end
            OP_POP: begin
              if (!res_full) begin
                cmd_take  = 1'b1;
                rd_en     = 1'b1;
                found_nxt = not_empty;
                state_nxt = S_POPRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOUSE: begin
        wr_en = 1'b1;
        priority if (steps_r[STEP_X]) begin
          wr_ent = '{EV_REL, REL_X, mreq_r.delta_x};
        end else if (steps_r[STEP_Y]) begin
          wr_ent = '{EV_REL, REL_Y, mreq_r.delta_y};
        end else if (steps_r[STEP_W]) begin
          wr_ent = '{EV_REL, REL_SCROLL, mreq_r.wheel_delta};
        end else if (steps_r[STEP_L]) begin
          wr_ent = '{EV_KEY, KEY_MOUSE_L, {31'd0, mreq_r.button_left}};
        end else if (steps_r[STEP_R]) begin
          wr_ent = '{EV_KEY, KEY_MOUSE_R, {31'd0, mreq_r.button_right}};
        end else begin
          wr_ent = '{EV_KEY, KEY_MOUSE_M, {31'd0, mreq_r.button_middle}};
        end
        // drop lowest pending step
        steps_nxt = steps_r & N_STEPS'(steps_r - 1'b1);
        state_nxt = (steps_nxt == '0) ? S_IDLE : S_MOUSE;
      end
      S_POPRD: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_data = '0;
    if (found_r) begin
      res_data = '{1'b1, rd_q_r.ev_type, rd_q_r.ev_code, rd_q_r.ev_value};
    end
  end

  // full ring: a write pushes the read index on, losing the oldest event
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    if (wr_en) begin
      wr_idx_nxt = wrap_inc(wr_idx_r);
      if (wr_idx_nxt == rd_idx_r) begin
        rd_idx_nxt = wrap_inc(rd_idx_r);
      end
    end else if (rd_en && not_empty) begin
      rd_idx_nxt = wrap_inc(rd_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem_r[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && (cmd.op == OP_MOUSE)) begin
      mreq_r <= cmd.req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      steps_r  <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      steps_r  <= steps_nxt;
      found_r  <= found_nxt;
    end
  end

  a_mouse_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOUSE) |-> (steps_r != '0))
    else $error("mouse sequence running with no step pending");

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POPRD) |=> (state_r != S_POPRD))
    else $error("pop read phase held over");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> !$past(res_full))
    else $error("pop started with result queue full");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_idx_r <= LAST) && (rd_idx_r <= LAST))
    else $error("ring index out of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("ring write and read issued together");

endmodule
